// ===== src/tbecq_pkg.sv =====
// ----------------------------------------------------------------------------
// tbecq_pkg
// shared types, codes and constants of the touch and button event queue
// ----------------------------------------------------------------------------
package tbecq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 32;
  localparam int unsigned COORD_W         = 9;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned OP_W            = 3;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned BTN_W           = 3;

  typedef enum logic [OP_W-1:0] {
    OP_TOUCH   = 3'd0,
    OP_BTN_EDGE = 3'd1,
    OP_VERDICT = 3'd2,
    OP_TICK    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_DOWN = 3'd0,
    KIND_MOVE = 3'd1,
    KIND_UP   = 3'd2,
    KIND_ZOOM = 3'd3,
    KIND_LONG = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_FIN,
    ST_COLLAPSE,
    ST_COL_BTN,
    ST_DRAIN
  } state_e;

  // one queue entry, 21 bits
  typedef struct packed {
    kind_e              kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } entry_t;

  // drain item handed to the output register
  typedef struct packed {
    logic              load;
    entry_t            ent;
    logic              last;
    logic [TIME_W-1:0] stamp;
  } out_load_t;

endpackage

// ===== src/tbecq_in_if.sv =====
// ----------------------------------------------------------------------------
// tbecq_in_if
// input channel: opcode and touch, button and tick fields
// ----------------------------------------------------------------------------
interface tbecq_in_if import tbecq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic               down_level;
  logic [COORD_W-1:0] touch_x;
  logic [COORD_W-1:0] touch_y;
  logic [BTN_W-1:0]   button_index;
  logic [TIME_W-1:0]  tick_time_us;

  modport source (
    output valid, opcode, down_level, touch_x, touch_y, button_index, tick_time_us,
    input  ready
  );
  modport sink (
    input  valid, opcode, down_level, touch_x, touch_y, button_index, tick_time_us,
    output ready
  );
endinterface

// ===== src/tbecq_out_if.sv =====
// ----------------------------------------------------------------------------
// tbecq_out_if
// output channel: drained events with tick stamp and last flag
// ----------------------------------------------------------------------------
interface tbecq_out_if import tbecq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  event_kind;
  logic [COORD_W-1:0] event_x;
  logic [COORD_W-1:0] event_y;
  logic [TIME_W-1:0]  event_time_us;
  logic               last_event;

  modport source (
    output valid, event_kind, event_x, event_y, event_time_us, last_event,
    input  ready
  );
  modport sink (
    input  valid, event_kind, event_x, event_y, event_time_us, last_event,
    output ready
  );
endinterface

// ===== src/tbecq_mem.sv =====
// ----------------------------------------------------------------------------
// tbecq_mem
// event store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module tbecq_mem import tbecq_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  entry_t        wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output entry_t        rdata_o
);

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tbecq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tbecq_ctrl
// sequencer: touch and button latching, queue insert, overflow walk, drain
// ----------------------------------------------------------------------------
module tbecq_ctrl import tbecq_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH),
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tbecq_in_if.sink      in_i,
  input  logic          out_free_i,
  output out_load_t     out_ld_o,
  output logic          we_o,
  output logic [AW-1:0] waddr_o,
  output entry_t        wdata_o,
  output logic          re_o,
  output logic [AW-1:0] raddr_o,
  input  entry_t        rdata_i
);

  state_e             state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  kind_e              last_kind_q, last_kind_d;
  logic [COORD_W-1:0] lat_x_q, lat_x_d, lat_y_q, lat_y_d;
  logic [COORD_W-1:0] dlv_x_q, dlv_x_d, dlv_y_q, dlv_y_d;
  logic               touching_q, touching_d;
  logic               dlv_touching_q, dlv_touching_d;
  logic               held_q, held_d;
  logic               seen_q, seen_d;
  logic [CW-1:0]      rptr_q, rptr_d;
  logic               rd_vld_q, rd_vld_d;
  logic [AW-1:0]      rd_addr_q, rd_addr_d;
  logic               found_q, found_d;
  logic [CW-1:0]      drain_n_q, drain_n_d;
  logic [CW-1:0]      drain_k_q, drain_k_d;
  entry_t             pend_q, pend_d;
  logic [TIME_W-1:0]  stamp_q, stamp_d;

  logic   ev_vld;
  entry_t ev;
  logic   issue;
  logic   walk_last;
  logic   drain_last;
  kind_e  rc_kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      count_q        <= '0;
      last_kind_q    <= KIND_DOWN;
      lat_x_q        <= '0;
      lat_y_q        <= '0;
      dlv_x_q        <= '0;
      dlv_y_q        <= '0;
      touching_q     <= 1'b0;
      dlv_touching_q <= 1'b0;
      held_q         <= 1'b0;
      seen_q         <= 1'b0;
      rptr_q         <= '0;
      rd_vld_q       <= 1'b0;
      rd_addr_q      <= '0;
      found_q        <= 1'b0;
      drain_n_q      <= '0;
      drain_k_q      <= '0;
    end else begin
      state_q        <= state_d;
      count_q        <= count_d;
      last_kind_q    <= last_kind_d;
      lat_x_q        <= lat_x_d;
      lat_y_q        <= lat_y_d;
      dlv_x_q        <= dlv_x_d;
      dlv_y_q        <= dlv_y_d;
      touching_q     <= touching_d;
      dlv_touching_q <= dlv_touching_d;
      held_q         <= held_d;
      seen_q         <= seen_d;
      rptr_q         <= rptr_d;
      rd_vld_q       <= rd_vld_d;
      rd_addr_q      <= rd_addr_d;
      found_q        <= found_d;
      drain_n_q      <= drain_n_d;
      drain_k_q      <= drain_k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q  <= pend_d;
    stamp_q <= stamp_d;
  end

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d        = state_q;
    count_d        = count_q;
    last_kind_d    = last_kind_q;
    lat_x_d        = lat_x_q;
    lat_y_d        = lat_y_q;
    dlv_x_d        = dlv_x_q;
    dlv_y_d        = dlv_y_q;
    touching_d     = touching_q;
    dlv_touching_d = dlv_touching_q;
    held_d         = held_q;
    seen_d         = seen_q;
    rptr_d         = rptr_q;
    rd_vld_d       = 1'b0;
    rd_addr_d      = rd_addr_q;
    found_d        = found_q;
    drain_n_d      = drain_n_q;
    drain_k_d      = drain_k_q;
    pend_d         = pend_q;
    stamp_d        = stamp_q;

    ev_vld     = 1'b0;
    ev         = '{kind: KIND_DOWN, x: '0, y: '0};
    issue      = 1'b0;
    walk_last  = 1'b0;
    drain_last = 1'b0;
    rc_kind    = KIND_DOWN;

    we_o     = 1'b0;
    waddr_o  = '0;
    wdata_o  = '{kind: KIND_DOWN, x: '0, y: '0};
    re_o     = 1'b0;
    raddr_o  = '0;
    out_ld_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          case (op_e'(in_i.opcode))
            OP_TOUCH: begin
              // ignore a release while up, or a press at the same spot while down
              if (!(in_i.down_level == touching_q &&
                    (!in_i.down_level ||
                     (in_i.touch_x == lat_x_q && in_i.touch_y == lat_y_q)))) begin
                ev_vld     = 1'b1;
                touching_d = in_i.down_level;
                if (!in_i.down_level) begin
                  ev = '{kind: KIND_UP, x: lat_x_q, y: lat_y_q};
                end else begin
                  ev = '{kind: (touching_q ? KIND_MOVE : KIND_DOWN),
                         x: in_i.touch_x, y: in_i.touch_y};
                  lat_x_d = in_i.touch_x;
                  lat_y_d = in_i.touch_y;
                end
              end
            end
            OP_BTN_EDGE: begin
              if (in_i.button_index == '0 && in_i.down_level != held_q) begin
                held_d = in_i.down_level;
                if (in_i.down_level) begin
                  seen_d = 1'b0;
                end
              end
            end
            OP_VERDICT: begin
              if (in_i.button_index == '0 && !seen_q &&
                  (in_i.down_level == held_q)) begin
                ev_vld = 1'b1;
                ev     = '{kind: (in_i.down_level ? KIND_LONG : KIND_ZOOM), x: '0, y: '0};
                seen_d = 1'b1;
              end
            end
            OP_TICK: begin
              count_d        = '0;
              dlv_touching_d = touching_q;
              dlv_x_d        = lat_x_q;
              dlv_y_d        = lat_y_q;
              stamp_d        = in_i.tick_time_us;
              if (count_q != '0) begin
                re_o      = 1'b1;
                raddr_o   = '0;
                drain_n_d = count_q;
                drain_k_d = '0;
                state_d   = ST_DRAIN;
              end
            end
            OP_CLEAR: begin
              count_d        = '0;
              lat_x_d        = '0;
              lat_y_d        = '0;
              dlv_x_d        = '0;
              dlv_y_d        = '0;
              touching_d     = 1'b0;
              dlv_touching_d = 1'b0;
              held_d         = 1'b0;
              seen_d         = 1'b0;
            end
            default: begin
            end
          endcase

          if (ev_vld) begin
            if (ev.kind == KIND_MOVE && count_q != '0 && last_kind_q == KIND_MOVE) begin
              // merge into the trailing move
              we_o    = 1'b1;
              waddr_o = AW'(count_q - CW'(1));
              wdata_o = ev;
            end else if (count_q < CW'(DEPTH)) begin
              we_o        = 1'b1;
              waddr_o     = AW'(count_q);
              wdata_o     = ev;
              count_d     = count_q + CW'(1);
              last_kind_d = ev.kind;
            end else begin
              // full: look for the oldest move
              pend_d  = ev;
              rptr_d  = '0;
              found_d = 1'b0;
              state_d = ST_WALK;
            end
          end
        end
      end

      ST_WALK: begin
        issue     = (rptr_q < count_q);
        re_o      = issue;
        raddr_o   = AW'(rptr_q);
        rd_vld_d  = issue;
        rd_addr_d = AW'(rptr_q);
        if (issue) begin
          rptr_d = rptr_q + CW'(1);
        end
        if (rd_vld_q) begin
          walk_last = (rd_addr_q == AW'(count_q - CW'(1)));
          if (found_q) begin
            // shift down over the removed move
            we_o    = 1'b1;
            waddr_o = AW'(rd_addr_q - AW'(1));
            wdata_o = rdata_i;
          end else if (rdata_i.kind == KIND_MOVE) begin
            found_d = 1'b1;
          end
          if (walk_last) begin
            state_d = (found_q || rdata_i.kind == KIND_MOVE) ? ST_FIN : ST_COLLAPSE;
          end
        end
      end

      ST_FIN: begin
        we_o        = 1'b1;
        waddr_o     = AW'(count_q - CW'(1));
        wdata_o     = pend_q;
        last_kind_d = pend_q.kind;
        state_d     = ST_IDLE;
      end

      ST_COLLAPSE: begin
        // no move to drop: at most one reconciling touch event
        count_d = '0;
        if (dlv_touching_q != touching_q) begin
          rc_kind = touching_q ? KIND_DOWN : KIND_UP;
        end else begin
          rc_kind = KIND_MOVE;
        end
        if (dlv_touching_q != touching_q ||
            (touching_q && (dlv_x_q != lat_x_q || dlv_y_q != lat_y_q))) begin
          we_o        = 1'b1;
          waddr_o     = '0;
          wdata_o     = '{kind: rc_kind, x: lat_x_q, y: lat_y_q};
          count_d     = CW'(1);
          last_kind_d = rc_kind;
        end
        if (pend_q.kind == KIND_ZOOM || pend_q.kind == KIND_LONG) begin
          state_d = ST_COL_BTN;
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_COL_BTN: begin
        we_o        = 1'b1;
        waddr_o     = AW'(count_q);
        wdata_o     = '{kind: pend_q.kind, x: '0, y: '0};
        count_d     = count_q + CW'(1);
        last_kind_d = pend_q.kind;
        state_d     = ST_IDLE;
      end

      ST_DRAIN: begin
        // read data holds entry drain_k_q until the next read
        if (out_free_i) begin
          drain_last     = ((drain_k_q + CW'(1)) == drain_n_q);
          out_ld_o.load  = 1'b1;
          out_ld_o.ent   = rdata_i;
          out_ld_o.last  = drain_last;
          out_ld_o.stamp = stamp_q;
          if (drain_last) begin
            state_d = ST_IDLE;
          end else begin
            re_o      = 1'b1;
            raddr_o   = AW'(drain_k_q + CW'(1));
            drain_k_d = drain_k_q + CW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/touch_button_event_coalescing_queue.sv =====
// ----------------------------------------------------------------------------
// touch_button_event_coalescing_queue
// queue of touch and button-0 events, drained and time stamped on a tick
// ----------------------------------------------------------------------------
// Touch items emit down, move or up only on a change, and a move that follows
// a move overwrites it in place. Button-0 verdicts add one zoom or long-press
// event per press. A tick item drains the whole queue, one event per cycle
// while the sink is ready, each stamped with the tick time, the final one
// with last_event set. Touch, button, verdict, clear and empty-tick items
// keep the input ready unless an event finds the queue full. A tick with
// queued events holds the input until its last event is loaded, since all
// reads share the single store read port. An event that meets a full queue
// walks every entry through that port to drop the oldest move, shift the
// rest down and write the new event last; with no move, the queue collapses to
// at most a reconciling touch event plus a new zoom or long-press event. The
// store needs no clearing pass: only entries below the fill count are read.
// ----------------------------------------------------------------------------
module touch_button_event_coalescing_queue import tbecq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tbecq_in_if.sink    in_i,
  tbecq_out_if.source out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  // event store port signals
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  // output register, decouples the drain from the sink
  out_load_t out_ld;
  logic      out_valid_q, out_valid_d;
  entry_t    out_ent_q;
  logic      out_last_q;
  logic [TIME_W-1:0] out_stamp_q;
  logic      out_free;

  assign out_free = !out_valid_q || out_o.ready;

  tbecq_ctrl #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .out_free_i (out_free),
    .out_ld_o   (out_ld),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  tbecq_mem #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // valid sets on a load, clears once the sink takes the item
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ld.load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (out_ld.load) begin
      out_ent_q   <= out_ld.ent;
      out_last_q  <= out_ld.last;
      out_stamp_q <= out_ld.stamp;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.event_kind    = out_ent_q.kind;
  assign out_o.event_x       = out_ent_q.x;
  assign out_o.event_y       = out_ent_q.y;
  assign out_o.event_time_us = out_stamp_q;
  assign out_o.last_event    = out_last_q;

endmodule

// ===== src/tbecq_checker.sv =====
// ----------------------------------------------------------------------------
// tbecq_checker
// port-level checks of the event queue, bound to the top level
// ----------------------------------------------------------------------------
module tbecq_checker import tbecq_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KIND_W-1:0]  event_kind_i,
  input logic [COORD_W-1:0] event_x_i,
  input logic [COORD_W-1:0] event_y_i,
  input logic [TIME_W-1:0]  event_time_i,
  input logic               last_event_i
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(event_kind_i) &&
      $stable(event_x_i) && $stable(event_y_i) && $stable(event_time_i) &&
      $stable(last_event_i))
    else $error("stalled output item changed");

  // no new input while a drain is still running
  a_drain_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_event_i |-> !in_ready_i)
    else $error("input ready during a drain");

  // button events carry no coordinates
  a_btn_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (event_kind_i == KIND_ZOOM || event_kind_i == KIND_LONG)
      |-> event_x_i == '0 && event_y_i == '0)
    else $error("button event with coordinates");

  // drained events carry a legal kind
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> event_kind_i <= KIND_LONG)
    else $error("illegal event kind");

endmodule

bind touch_button_event_coalescing_queue tbecq_checker u_tbecq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .event_kind_i (out_o.event_kind),
  .event_x_i    (out_o.event_x),
  .event_y_i    (out_o.event_y),
  .event_time_i (out_o.event_time_us),
  .last_event_i (out_o.last_event)
);
